/* rtl/core/rolling_hash_pattern_matcher_core_defines.svh */
// Assertion macros shared by the rolling hash matcher RTL.
`ifndef ROLLING_HASH_PATTERN_MATCHER_CORE_DEFINES_SVH
`define ROLLING_HASH_PATTERN_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHPM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rhpm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHPM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rhpm assertion failed");

`endif

/* rtl/core/rhpm_pkg.sv */
// Shared types and constants for the rolling hash pattern matcher.
package rhpm_pkg;

    localparam int BYTE_W    = 8;
    localparam int HASH_W    = 64;
    localparam int OUT_POS_W = 16;

    localparam logic [HASH_W-1:0] HASH_BASE = 64'd1001;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // Controller to datapath commands, one cycle each.
    typedef struct packed {
        logic load_item;
        logic pat_restart;
        logic pat_step;
        logic txt_mul;
        logic txt_upd;
        logic txt_cmp;
        logic v_read;
        logic v_step;
        logic found_set;
        logic out_load;
    } rhpm_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic pat_complete;
        logic hash_hit;
        logic byte_eq;
        logic walk_last;
        logic item_last;
    } rhpm_sts_t;

endpackage

/* rtl/core/rolling_hash_pattern_matcher_core.sv */
// Top level of the rolling hash pattern matcher: controller plus datapath.
// Pattern byte: accept, then store and hash. Text byte: accept, leaving-byte multiply, hash update,
// hash compare, in that order.
// Hash hit: the verify walk adds a RAM read and a compare per pattern byte.
// Loading a result into the output register stalls while that register holds an unread one;
// one item at a time. Reset: synchronous active-low aresetn clears lengths, hashes, counters.
module rolling_hash_pattern_matcher_core import rhpm_pkg::*; #(
    parameter int MAX_PATTERN_LEN = 32,
    parameter int POSITION_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,    // [7:0] byte_value
    input  logic [0:0]           s_tuser,    // [0] mode
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_POS_W-1:0] m_tdata,    // [15:0] match_position
    output logic [0:0]           m_tuser,    // [0] match_found
    output logic                 m_tlast
);

    rhpm_cmd_t cmd;
    rhpm_sts_t sts;

    rhpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rhpm_dp #(
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .POSITION_BITS   (POSITION_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

/* rtl/core/rhpm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rhpm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                          rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/rhpm_dp.sv */
// Datapath: pattern and window RAMs, hashes, ring pointers and result register.
`include "rolling_hash_pattern_matcher_core_defines.svh"

module rhpm_dp import rhpm_pkg::*; #(
    parameter int MAX_PATTERN_LEN = 32,
    parameter int POSITION_BITS   = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rhpm_cmd_t            cmd,
    output rhpm_sts_t            sts,
    input  logic [BYTE_W-1:0]    s_tdata,
    input  logic                 s_tlast,
    output logic [OUT_POS_W-1:0] m_tdata,
    output logic [0:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
    localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PB = POSITION_BITS;

    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [LW-1:0]        len_reg, len_next;
    logic                 complete_reg, complete_next;
    logic [HASH_W-1:0]    q_reg, q_next;
    logic [HASH_W-1:0]    tw_reg, tw_next;
    logic [HASH_W-1:0]    g_reg, g_next;
    logic [HASH_W-1:0]    gs_reg, gs_next;
    logic [HASH_W-1:0]    prod_reg, prod_next;
    logic [AW-1:0]        slot_reg, slot_next;
    logic [LW-1:0]        fill_reg, fill_next;
    logic [PB-1:0]        pos_reg, pos_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [AW-1:0]        j_reg, j_next;
    logic                 found_reg, found_next;
    logic [OUT_POS_W-1:0] out_pos_reg, out_pos_next;
    logic                 out_found_reg, out_found_next;
    logic                 out_last_reg, out_last_next;

    logic [BYTE_W-1:0]    pat_rdata;
    logic [BYTE_W-1:0]    ring_rdata;
    logic [BYTE_W-1:0]    oldest;
    logic                 pat_room;
    logic                 full;
    logic [LW-1:0]        slot_inc;
    logic [AW-1:0]        slot_adv;
    logic [LW-1:0]        j_inc;
    logic [AW-1:0]        j_adv;
    logic [PB-1:0]        start_pos;

    rhpm_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (MAX_PATTERN_LEN)
    ) u_pat_ram (
        .aclk  (aclk),
        .we    (cmd.pat_step && pat_room),
        .waddr (len_reg[AW-1:0]),
        .wdata (byte_reg),
        .raddr (i_reg),
        .rdata (pat_rdata)
    );

    rhpm_ram #(
        .DATA_W (BYTE_W),
        .DEPTH  (MAX_PATTERN_LEN)
    ) u_ring_ram (
        .aclk  (aclk),
        .we    (cmd.txt_mul),
        .waddr (slot_reg),
        .wdata (byte_reg),
        .raddr (cmd.v_read ? j_reg : slot_reg),
        .rdata (ring_rdata)
    );

    assign pat_room  = len_reg < LW'(MAX_PATTERN_LEN);
    assign full      = fill_reg == len_reg;
    assign oldest    = full ? ring_rdata : '0;
    assign slot_inc  = LW'(slot_reg) + LW'(1);
    assign slot_adv  = (slot_inc >= len_reg) ? '0 : slot_inc[AW-1:0];
    assign j_inc     = LW'(j_reg) + LW'(1);
    assign j_adv     = (j_inc >= len_reg) ? '0 : j_inc[AW-1:0];
    assign start_pos = pos_reg - PB'(len_reg);

    // The window hash keeps the newest byte at weight 1 and the oldest at 1001^(L-1);
    // the pattern hash uses the same ordering, so a true match always hits.
    always_comb begin
        byte_next      = byte_reg;
        last_next      = last_reg;
        len_next       = len_reg;
        complete_next  = complete_reg;
        q_next         = q_reg;
        tw_next        = tw_reg;
        g_next         = g_reg;
        gs_next        = gs_reg;
        prod_next      = prod_reg;
        slot_next      = slot_reg;
        fill_next      = fill_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        found_next     = found_reg;
        out_pos_next   = out_pos_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;

        if (cmd.load_item) begin
            byte_next  = s_tdata;
            last_next  = s_tlast;
            found_next = 1'b0;
        end

        if (cmd.pat_restart) begin
            len_next      = '0;
            complete_next = 1'b0;
            q_next        = '0;
            tw_next       = HASH_W'(1);
            g_next        = '0;
            gs_next       = '0;
            slot_next     = '0;
            fill_next     = '0;
            pos_next      = '0;
        end

        if (cmd.pat_step) begin
            if (pat_room) begin
                q_next   = q_reg * HASH_BASE + HASH_W'(byte_reg);
                tw_next  = tw_reg * HASH_BASE;
                len_next = len_reg + LW'(1);
            end
            if (last_reg) begin
                complete_next = 1'b1;
            end
        end

        // Weight of the byte leaving the window is 1001^L after the scale step.
        if (cmd.txt_mul) begin
            prod_next = tw_reg * HASH_W'(oldest);
        end

        if (cmd.txt_upd) begin
            g_next    = gs_reg - prod_reg + HASH_W'(byte_reg);
            slot_next = slot_adv;
            if (!full) begin
                fill_next = fill_reg + LW'(1);
            end
            pos_next  = pos_reg + PB'(1);
            i_next    = '0;
            j_next    = slot_adv;
        end

        if (cmd.txt_cmp) begin
            gs_next = g_reg * HASH_BASE;
        end

        if (cmd.v_step) begin
            i_next = i_reg + AW'(1);
            j_next = j_adv;
        end

        if (cmd.found_set) begin
            found_next = 1'b1;
        end

        if (cmd.out_load) begin
            out_found_next = found_reg;
            out_last_next  = last_reg;
            out_pos_next   = found_reg ? OUT_POS_W'(start_pos) : '0;
            // Final text byte: drop the text state, keep the pattern.
            if (last_reg) begin
                g_next    = '0;
                gs_next   = '0;
                slot_next = '0;
                fill_next = '0;
                pos_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            complete_reg <= 1'b0;
            q_reg        <= '0;
            tw_reg       <= HASH_W'(1);
            g_reg        <= '0;
            gs_reg       <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            pos_reg      <= '0;
            found_reg    <= 1'b0;
        end else begin
            len_reg      <= len_next;
            complete_reg <= complete_next;
            q_reg        <= q_next;
            tw_reg       <= tw_next;
            g_reg        <= g_next;
            gs_reg       <= gs_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            pos_reg      <= pos_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        out_pos_reg   <= out_pos_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    assign sts.pat_complete = complete_reg;
    assign sts.hash_hit     = full && (g_reg == q_reg);
    assign sts.byte_eq      = ring_rdata == pat_rdata;
    assign sts.walk_last    = (LW'(i_reg) + LW'(1)) == len_reg;
    assign sts.item_last    = last_reg;

    assign m_tdata    = out_pos_reg;
    assign m_tuser[0] = out_found_reg;
    assign m_tlast    = out_last_reg;

    `RHPM_ASSERT_IMPL(a_fill_within_len, 1'b1, fill_reg <= len_reg)
    `RHPM_ASSERT_IMPL(a_slot_within_len, complete_reg, LW'(slot_reg) < len_reg)
    `RHPM_ASSERT_IMPL(a_match_had_hit, cmd.out_load && found_reg, g_reg == q_reg)

endmodule

/* rtl/core/rhpm_ctrl.sv */
// Controller: sequences pattern loads, hash updates, verify walk and result handoff.
`include "rolling_hash_pattern_matcher_core_defines.svh"

module rhpm_ctrl import rhpm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [0:0] s_tuser,
    output logic       m_tvalid,
    input  logic       m_tready,
    output rhpm_cmd_t  cmd,
    input  rhpm_sts_t  sts
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAT   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_VADDR = 3'd5;
    localparam logic [2:0] ST_VCMP  = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_item = 1'b1;
                    if (s_tuser[0] == MODE_PATTERN) begin
                        cmd.pat_restart = sts.pat_complete;
                        state_next      = ST_PAT;
                    end else if (sts.pat_complete) begin
                        state_next = ST_MUL;
                    end
                    // Text with no pattern loaded: drop it.
                end
            end
            ST_PAT: begin
                cmd.pat_step = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_MUL: begin
                cmd.txt_mul = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                cmd.txt_upd = 1'b1;
                state_next  = ST_CMP;
            end
            ST_CMP: begin
                cmd.txt_cmp = 1'b1;
                if (sts.hash_hit) begin
                    state_next = ST_VADDR;
                end else if (sts.item_last) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_VADDR: begin
                cmd.v_read = 1'b1;
                state_next = ST_VCMP;
            end
            ST_VCMP: begin
                cmd.v_step = 1'b1;
                if (!sts.byte_eq) begin
                    state_next = sts.item_last ? ST_OUT : ST_IDLE;
                end else if (sts.walk_last) begin
                    cmd.found_set = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    state_next = ST_VADDR;
                end
            end
            ST_OUT: begin
                // Hold until the result register is free.
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `RHPM_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_tvalid_reg || m_tready)
    `RHPM_ASSERT_NEXT(a_text_starts_hash, accept && (s_tuser[0] == MODE_TEXT) && sts.pat_complete, state_reg == ST_MUL)
    `RHPM_ASSERT_NEXT(a_miss_no_result, (state_reg == ST_VCMP) && !sts.byte_eq && !sts.item_last, state_reg == ST_IDLE)

endmodule
